>>> src/assert_macros.svh
// assertion macros shared by the scanner rtl
// each macro checks one implication on the rising edge of clk, held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSSX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSSX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mssx_pkg.sv
// shared constants and types for the masked signature scanner
// no dependencies
`timescale 1ns / 1ps

package mssx_pkg;

    // default sizes
    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_BLOCK_DEF   = 1048576;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int OFF_W    = 20;
    localparam int CFG_W    = 64;
    localparam int PLEN_W   = 5;
    localparam int FSTART_W = 4;
    localparam int FBYTES_W = 3;
    localparam int CMPEN_W  = 16;

    // register reset values
    localparam logic [PLEN_W-1:0]   PLEN_RST   = 5'd1;
    localparam logic [FBYTES_W-1:0] FBYTES_RST = 3'd4;
    localparam logic [VALUE_W-1:0]  LIMIT_RST  = 32'd536870912;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_CMP_EN  = 3'd2,
        REG_PLEN    = 3'd3,
        REG_FSTART  = 3'd4,
        REG_FBYTES  = 3'd5,
        REG_LIMIT   = 3'd6
    } cfg_reg_t;

endpackage

>>> src/mssx_cell.sv
// one window cell: holds one byte of the sliding window and compares it to its pattern byte
// depends on mssx_pkg
`timescale 1ns / 1ps

module mssx_cell #(
    parameter int MAX_PATTERN = mssx_pkg::MAX_PATTERN_DEF,
    parameter int IDX         = 0
) (
    input  logic                                clk,
    input  logic                                shift_en,
    input  logic [mssx_pkg::BYTE_W-1:0]         byte_in,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]    len,
    input  logic [mssx_pkg::CFG_W-1:0]          pattern_low,
    input  logic [mssx_pkg::CFG_W-1:0]          pattern_high,
    input  logic [mssx_pkg::CMPEN_W-1:0]        compare_enable,
    output logic [mssx_pkg::BYTE_W-1:0]         byte_out,
    output logic                                mismatch
);

    localparam int LW = $clog2(MAX_PATTERN+1);

    logic [mssx_pkg::BYTE_W-1:0] byte_reg;
    logic [LW-1:0]               k;
    logic [3:0]                  kk;
    logic                        in_win;
    logic                        care;
    logic [mssx_pkg::BYTE_W-1:0] pbyte;

    // window byte, shifted in from the younger neighbor
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // this cell sits at pattern position len-1-IDX
    always_comb
    begin
        in_win = (LW'(IDX) < len);
        k      = len - LW'(IDX) - LW'(1);
        kk     = 4'(k);
        care   = in_win && (int'(k) < mssx_pkg::CMPEN_W) && compare_enable[kk];
        if (kk[3])
        begin
            pbyte = pattern_high[{kk[2:0], 3'b000} +: mssx_pkg::BYTE_W];
        end
        else
        begin
            pbyte = pattern_low[{kk[2:0], 3'b000} +: mssx_pkg::BYTE_W];
        end
        mismatch = care && (byte_reg != pbyte);
    end

endmodule

>>> src/mssx_field.sv
// field extractor: reads a little-endian field of 1, 2 or 4 bytes out of the window cells
// depends on mssx_pkg
`timescale 1ns / 1ps

module mssx_field #(
    parameter int MAX_PATTERN = mssx_pkg::MAX_PATTERN_DEF
) (
    input  logic [mssx_pkg::BYTE_W-1:0]         window [MAX_PATTERN],
    input  logic [$clog2(MAX_PATTERN+1)-1:0]    len,
    input  logic [mssx_pkg::FSTART_W-1:0]       field_start,
    input  logic [mssx_pkg::FBYTES_W-1:0]       field_bytes,
    output logic [mssx_pkg::VALUE_W-1:0]        value
);

    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [mssx_pkg::FBYTES_W-1:0] FB_ONE = 3'd1;
    localparam logic [mssx_pkg::FBYTES_W-1:0] FB_TWO = 3'd2;

    // field width: one, two, otherwise four bytes
    always_comb
    begin
        int width;
        int ki;
        int pos;
        priority if (field_bytes == FB_ONE)
        begin
            width = 1;
        end
        else if (field_bytes == FB_TWO)
        begin
            width = 2;
        end
        else
        begin
            width = 4;
        end
        value = '0;
        // window byte k lives in cell len-1-k, bytes past the window read zero
        for (int i = 0; i < 4; i++)
        begin
            ki  = int'(field_start) + i;
            pos = int'(len) - 1 - ki;
            if ((i < width) && (ki < int'(len)))
            begin
                value[8*i +: 8] = window[PW'(pos)];
            end
        end
    end

endmodule

>>> src/masked_signature_scan_extract.sv
// the last byte of a block is registered in the compare stage, then its result is loaded into the output register
// throughput: one byte per cycle; a full, stalled output holds the last byte of the next block
// the window is a chain of byte cells compared in parallel in one compare stage
// reset: control, counters, match state and registers clear at once, no clearing pass
// the window cells are not cleared; only bytes of the current block are ever tested
`timescale 1ns / 1ps
`include "assert_macros.svh"

module masked_signature_scan_extract #(
    parameter int MAX_PATTERN = mssx_pkg::MAX_PATTERN_DEF,
    parameter int MAX_BLOCK   = mssx_pkg::MAX_BLOCK_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [2:0]                          cfg_index,
    input  logic [mssx_pkg::CFG_W-1:0]          cfg_data,
    // byte requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mssx_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                last_byte,
    // result requests
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [mssx_pkg::VALUE_W-1:0]        field_value,
    output logic [mssx_pkg::OFF_W-1:0]          match_offset
);

    localparam int LW = $clog2(MAX_PATTERN+1);
    localparam int CW = $clog2(MAX_BLOCK+1);
    localparam int TW = ((CW > LW) ? CW : LW) + 1;
    localparam int SW = ((CW > mssx_pkg::OFF_W) ? CW : mssx_pkg::OFF_W) + 1;

    typedef struct packed {
        logic                       last;
        logic                       test;
        logic [mssx_pkg::OFF_W-1:0] offset;
    } s1_t;

    // configuration registers
    logic [mssx_pkg::CFG_W-1:0]    pat_lo_reg;
    logic [mssx_pkg::CFG_W-1:0]    pat_hi_reg;
    logic [mssx_pkg::CMPEN_W-1:0]  cmp_en_reg;
    logic [mssx_pkg::PLEN_W-1:0]   plen_reg;
    logic [mssx_pkg::FSTART_W-1:0] fstart_reg;
    logic [mssx_pkg::FBYTES_W-1:0] fbytes_reg;
    logic [mssx_pkg::VALUE_W-1:0]  limit_reg;

    logic [LW-1:0] len;
    logic          in_accept;
    logic          out_accept;

    // block position
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          test_now;
    logic [SW-1:0] off_full;

    // compare stage
    logic s1_valid_reg;
    s1_t  s1_reg;
    logic s1_blocked;
    logic s1_go;

    // window chain
    logic [mssx_pkg::BYTE_W-1:0]  win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]       cell_miss;
    logic [mssx_pkg::VALUE_W-1:0] field_now;
    logic                         hit;

    // match state
    logic                         latched_reg;
    logic [mssx_pkg::VALUE_W-1:0] held_value_reg;
    logic [mssx_pkg::OFF_W-1:0]   held_offset_reg;

    // output register
    logic                         out_valid_reg;
    logic                         found_reg;
    logic [mssx_pkg::VALUE_W-1:0] value_reg;
    logic [mssx_pkg::OFF_W-1:0]   offset_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            cmp_en_reg <= '0;
            plen_reg   <= mssx_pkg::PLEN_RST;
            fstart_reg <= '0;
            fbytes_reg <= mssx_pkg::FBYTES_RST;
            limit_reg  <= mssx_pkg::LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mssx_pkg::REG_PAT_LO: pat_lo_reg <= cfg_data;
                mssx_pkg::REG_PAT_HI: pat_hi_reg <= cfg_data;
                mssx_pkg::REG_CMP_EN: cmp_en_reg <= cfg_data[mssx_pkg::CMPEN_W-1:0];
                mssx_pkg::REG_PLEN:   plen_reg   <= cfg_data[mssx_pkg::PLEN_W-1:0];
                mssx_pkg::REG_FSTART: fstart_reg <= cfg_data[mssx_pkg::FSTART_W-1:0];
                mssx_pkg::REG_FBYTES: fbytes_reg <= cfg_data[mssx_pkg::FBYTES_W-1:0];
                mssx_pkg::REG_LIMIT:  limit_reg  <= cfg_data[mssx_pkg::VALUE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective window length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (plen_reg == '0)
        begin
            len = LW'(1);
        end
        else if (int'(plen_reg) > MAX_PATTERN)
        begin
            len = LW'(MAX_PATTERN);
        end
        else
        begin
            len = LW'(plen_reg);
        end
    end

    // handshakes; the input stalls only while a finished block waits on a full output
    assign s1_blocked = s1_valid_reg && s1_reg.last && out_valid_reg && out_stall;
    assign in_stall   = s1_blocked;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign s1_go      = s1_valid_reg && !s1_blocked;

    // byte index within the block and window test gating
    always_comb
    begin
        test_now = (count_reg < CW'(MAX_BLOCK))
                   && ((TW'(count_reg) + TW'(1)) >= TW'(len));
        off_full = SW'(count_reg) + SW'(1) - SW'(len);
        if (last_byte)
        begin
            count_next = '0;
        end
        else if (count_reg < CW'(MAX_BLOCK))
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg <= count_next;
            end
            s1_valid_reg <= in_accept || s1_blocked;
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.last   <= last_byte;
            s1_reg.test   <= test_now;
            s1_reg.offset <= off_full[mssx_pkg::OFF_W-1:0];
        end
    end

    // window cell chain, cell 0 takes the newest byte
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [mssx_pkg::BYTE_W-1:0] cell_in;
        if (j == 0)
        begin : g_head
            assign cell_in = data_byte;
        end
        else
        begin : g_link
            assign cell_in = win[j-1];
        end
        mssx_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .IDX         (j)
        ) u_cell (
            .clk            (clk),
            .shift_en       (in_accept),
            .byte_in        (cell_in),
            .len            (len),
            .pattern_low    (pat_lo_reg),
            .pattern_high   (pat_hi_reg),
            .compare_enable (cmp_en_reg),
            .byte_out       (win[j]),
            .mismatch       (cell_miss[j])
        );
    end

    // field read out of the window
    mssx_field #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_field (
        .window      (win),
        .len         (len),
        .field_start (fstart_reg),
        .field_bytes (fbytes_reg),
        .value       (field_now)
    );

    assign hit = s1_reg.test && !latched_reg && (cell_miss == '0) && (field_now < limit_reg);

    // first accepted match of the block, cleared when the block ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg     <= 1'b0;
            held_value_reg  <= '0;
            held_offset_reg <= '0;
        end
        else if (s1_go)
        begin
            if (s1_reg.last)
            begin
                latched_reg     <= 1'b0;
                held_value_reg  <= '0;
                held_offset_reg <= '0;
            end
            else if (hit)
            begin
                latched_reg     <= 1'b1;
                held_value_reg  <= field_now;
                held_offset_reg <= s1_reg.offset;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            value_reg     <= '0;
            offset_reg    <= '0;
        end
        else if (s1_go && s1_reg.last)
        begin
            out_valid_reg <= 1'b1;
            found_reg     <= latched_reg || hit;
            if (latched_reg)
            begin
                value_reg  <= held_value_reg;
                offset_reg <= held_offset_reg;
            end
            else if (hit)
            begin
                value_reg  <= field_now;
                offset_reg <= s1_reg.offset;
            end
            else
            begin
                value_reg  <= '0;
                offset_reg <= '0;
            end
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign field_value  = value_reg;
    assign match_offset = offset_reg;

    // a finished block loads the output and leaves the match state clear
    `MSSX_ASSERT_NXT(a_block_end, s1_go && s1_reg.last, out_valid_reg && !latched_reg, "block end not taken")
    // a match is only latched by a tested window
    `MSSX_ASSERT_IMP(a_latch_src, $rose(latched_reg), $past(s1_valid_reg && s1_reg.test), "latch without test")
    // a result without a match carries zero value and offset
    `MSSX_ASSERT_IMP(a_no_match, out_valid_reg && !found_reg, value_reg == '0 && offset_reg == '0, "stale result")
    // byte count saturates at the block limit
    `MSSX_ASSERT_IMP(a_count_sat, in_accept, count_reg <= CW'(MAX_BLOCK), "byte count overrun")

endmodule

>>> dv/tb_masked_signature_scan_extract.sv
// self-checking testbench for the masked signature scanner
// depends on mssx_pkg and masked_signature_scan_extract; stands alone otherwise
`timescale 1ns / 1ps

module tb_masked_signature_scan_extract;

    // run sizing
    localparam int unsigned RANDOM_BYTES = 1450;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STEADY_SPAN = 400;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned IDLE_PCT = 33;

    // register index that maps to no register
    localparam logic [2:0] REG_SPARE = 3'd7;

    // planned driver actions
    typedef enum logic [1:0] {
        ACT_BYTE,
        ACT_WRITE,
        ACT_DRAIN
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t                       kind;
        logic [mssx_pkg::BYTE_W-1:0]      data;
        logic                             last;
        logic [2:0]                       index;
        logic [mssx_pkg::CFG_W-1:0]       value;
    } plan_entry_t;

    typedef struct packed {
        logic                             found;
        logic [mssx_pkg::VALUE_W-1:0]     value;
        logic [mssx_pkg::OFF_W-1:0]       offset;
    } scan_report_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                             cfg_write = 1'b0;
    logic [2:0]                       cfg_index = '0;
    logic [mssx_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic [mssx_pkg::BYTE_W-1:0]      data_byte = '0;
    logic                             last_byte = 1'b0;
    logic                             out_stall = 1'b0;

    // block outputs
    logic                             in_stall;
    logic                             out_valid;
    logic                             found;
    logic [mssx_pkg::VALUE_W-1:0]     field_value;
    logic [mssx_pkg::OFF_W-1:0]       match_offset;

    // request plan and expected scan reports
    plan_entry_t  byte_plan [$];
    scan_report_t pending_reports [$];
    plan_entry_t  next_req;

    // planning shadow of the registers, used to embed the signature
    logic [2*mssx_pkg::CFG_W-1:0]     plan_pat = '0;
    logic [mssx_pkg::CMPEN_W-1:0]     plan_cmpen = '0;
    logic [mssx_pkg::PLEN_W-1:0]      plan_plen = mssx_pkg::PLEN_RST;
    int unsigned                      planned_bytes = 0;

    // scanner prediction: registers
    logic [2*mssx_pkg::CFG_W-1:0]     cur_pat = '0;
    logic [mssx_pkg::CMPEN_W-1:0]     cur_cmpen = '0;
    logic [mssx_pkg::PLEN_W-1:0]      cur_plen = mssx_pkg::PLEN_RST;
    logic [mssx_pkg::FSTART_W-1:0]    cur_fstart = '0;
    logic [mssx_pkg::FBYTES_W-1:0]    cur_fbytes = mssx_pkg::FBYTES_RST;
    logic [mssx_pkg::VALUE_W-1:0]     cur_limit = mssx_pkg::LIMIT_RST;

    // scanner prediction: block state, win[0] is the newest byte
    logic [mssx_pkg::BYTE_W-1:0]      win [0:mssx_pkg::MAX_PATTERN_DEF-1];
    logic [20:0]                      scan_count = '0;
    logic                             latched = 1'b0;
    logic [mssx_pkg::VALUE_W-1:0]     held_value = '0;
    logic [mssx_pkg::OFF_W-1:0]       held_offset = '0;

    // run bookkeeping
    logic        byte_taken = 1'b0;
    int unsigned bytes_in = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count = 0;
    int unsigned settle_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned hold_mark = 0;

    masked_signature_scan_extract i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .field_value  (field_value),
        .match_offset (match_offset)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int j = 0; j < mssx_pkg::MAX_PATTERN_DEF; j++)
        begin
            win[j] = '0;
        end
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0d ns error: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // stretch of the run where neither side idles
    function automatic bit steady_stretch();
        return (bytes_in >= hold_mark + STEADY_SPAN) && (bytes_in < hold_mark + 2 * STEADY_SPAN);
    endfunction

    // effective window length, clamped to 1..MAX_PATTERN
    function automatic int unsigned clamp_len(input logic [mssx_pkg::PLEN_W-1:0] plen);
        if (plen == '0)
        begin
            return 32'd1;
        end
        else if (32'(plen) > 32'(mssx_pkg::MAX_PATTERN_DEF))
        begin
            return 32'(mssx_pkg::MAX_PATTERN_DEF);
        end
        return 32'(plen);
    endfunction

    // predicted register write
    task automatic apply_write(input logic [2:0] index,
                               input logic [mssx_pkg::CFG_W-1:0] value);
        case (index)
            mssx_pkg::REG_PAT_LO: cur_pat[mssx_pkg::CFG_W-1:0] = value;
            mssx_pkg::REG_PAT_HI: cur_pat[2*mssx_pkg::CFG_W-1:mssx_pkg::CFG_W] = value;
            mssx_pkg::REG_CMP_EN: cur_cmpen = value[mssx_pkg::CMPEN_W-1:0];
            mssx_pkg::REG_PLEN:   cur_plen = value[mssx_pkg::PLEN_W-1:0];
            mssx_pkg::REG_FSTART: cur_fstart = value[mssx_pkg::FSTART_W-1:0];
            mssx_pkg::REG_FBYTES: cur_fbytes = value[mssx_pkg::FBYTES_W-1:0];
            mssx_pkg::REG_LIMIT:  cur_limit = value[mssx_pkg::VALUE_W-1:0];
            default:    ;
        endcase
    endtask

    // predicted scanner step for one accepted byte
    task automatic advance_scanner(input logic [mssx_pkg::BYTE_W-1:0] data, input logic last);
        int unsigned  len;
        int unsigned  width;
        int unsigned  pos;
        int unsigned  k;
        bit           hit;
        logic [31:0]  value;
        scan_report_t rpt;
        len = clamp_len(cur_plen);
        for (k = mssx_pkg::MAX_PATTERN_DEF - 1; k > 0; k--)
        begin
            win[k] = win[k-1];
        end
        win[0] = data;
        // only windows wholly inside the block are tested
        if (!latched && (32'(scan_count) < 32'(mssx_pkg::MAX_BLOCK_DEF))
            && (32'(scan_count) + 32'd1 >= len))
        begin
            hit = 1'b1;
            for (k = 0; k < len; k++)
            begin
                if (cur_cmpen[k] && win[len-1-k] != cur_pat[8*k +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                width = (cur_fbytes == 3'd1) ? 1 : ((cur_fbytes == 3'd2) ? 2 : 4);
                value = '0;
                for (k = 0; k < width; k++)
                begin
                    pos = 32'(cur_fstart) + k;
                    if (pos < len)
                    begin
                        value[8*k +: 8] = win[len-1-pos];
                    end
                end
                if (value < cur_limit)
                begin
                    latched = 1'b1;
                    held_value = value;
                    held_offset = mssx_pkg::OFF_W'(32'(scan_count) + 32'd1 - len);
                end
            end
        end
        if (32'(scan_count) < 32'(mssx_pkg::MAX_BLOCK_DEF))
        begin
            scan_count++;
        end
        if (last)
        begin
            rpt.found = latched;
            rpt.value = latched ? held_value : '0;
            rpt.offset = latched ? held_offset : '0;
            pending_reports.push_back(rpt);
            scan_count = '0;
            latched = 1'b0;
            held_value = '0;
            held_offset = '0;
        end
    endtask

    // planning helpers
    task automatic plan_byte(input logic [mssx_pkg::BYTE_W-1:0] data, input logic last);
        plan_entry_t e;
        e = '0;
        e.kind = ACT_BYTE;
        e.data = data;
        e.last = last;
        byte_plan.push_back(e);
        planned_bytes++;
    endtask

    task automatic plan_write(input logic [2:0] index, input logic [mssx_pkg::CFG_W-1:0] value);
        plan_entry_t e;
        e = '0;
        e.kind = ACT_WRITE;
        e.index = index;
        e.value = value;
        byte_plan.push_back(e);
        case (index)
            mssx_pkg::REG_PAT_LO: plan_pat[mssx_pkg::CFG_W-1:0] = value;
            mssx_pkg::REG_PAT_HI: plan_pat[2*mssx_pkg::CFG_W-1:mssx_pkg::CFG_W] = value;
            mssx_pkg::REG_CMP_EN: plan_cmpen = value[mssx_pkg::CMPEN_W-1:0];
            mssx_pkg::REG_PLEN:   plan_plen = value[mssx_pkg::PLEN_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic plan_drain();
        plan_entry_t e;
        e = '0;
        e.kind = ACT_DRAIN;
        byte_plan.push_back(e);
    endtask

    // one block of random bytes, optionally carrying the signature and a corrupted byte
    task automatic plan_block(input int unsigned blen, input int unsigned hits, input bit mangle);
        logic [mssx_pkg::BYTE_W-1:0] blk [$];
        int unsigned                 len;
        int unsigned                 pos;
        int unsigned                 i;
        int unsigned                 k;
        len = clamp_len(plan_plen);
        for (i = 0; i < blen; i++)
        begin
            blk.push_back(mssx_pkg::BYTE_W'($urandom_range(255, 0)));
        end
        if (blen >= len)
        begin
            repeat (hits)
            begin
                pos = $urandom_range(blen - len, 0);
                for (k = 0; k < len; k++)
                begin
                    if (plan_cmpen[k])
                    begin
                        blk[pos+k] = plan_pat[8*k +: 8];
                    end
                end
            end
            if (mangle)
            begin
                pos = $urandom_range(blen - 1, 0);
                blk[pos] = ~blk[pos];
            end
        end
        for (i = 0; i < blen; i++)
        begin
            plan_byte(blk[i], i == blen - 1);
        end
    endtask

    // request driver, changes inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cfg_write = 1'b0;
            if (!in_valid || byte_taken)
            begin
                in_valid = 1'b0;
                if (settle_left != 0)
                begin
                    settle_left--;
                end
                else if (byte_plan.size() != 0)
                begin
                    next_req = byte_plan[0];
                    case (next_req.kind)
                        ACT_DRAIN:
                        begin
                            // hold off until every expected report is back
                            if (pending_reports.size() == 0)
                            begin
                                settle_left = SETTLE_CYCLES;
                                void'(byte_plan.pop_front());
                            end
                        end
                        ACT_WRITE:
                        begin
                            cfg_write = 1'b1;
                            cfg_index = next_req.index;
                            cfg_data = next_req.value;
                            void'(byte_plan.pop_front());
                        end
                        default:
                        begin
                            if (steady_stretch() || $urandom_range(99, 0) >= IDLE_PCT)
                            begin
                                in_valid = 1'b1;
                                data_byte = next_req.data;
                                last_byte = next_req.last;
                                void'(byte_plan.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (!hold_done && hold_mark != 0 && bytes_in >= hold_mark)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end
        else
        begin
            out_stall = !steady_stretch() && ($urandom_range(99, 0) < IDLE_PCT);
        end
    end

    // monitor: sample requests on the rising edge, predict and check
    always @(posedge clk)
    begin
        scan_report_t want;
        if (rst_n)
        begin
            byte_taken <= in_valid && !in_stall;
            if (cfg_write)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                advance_scanner(data_byte, last_byte);
                bytes_in++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    report_mismatch("report with nothing expected", field_value, '0);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (found !== want.found)
                    begin
                        report_mismatch("found", 32'(found), 32'(want.found));
                    end
                    if (field_value !== want.value)
                    begin
                        report_mismatch("field_value", field_value, want.value);
                    end
                    if (match_offset !== want.offset)
                    begin
                        report_mismatch("match_offset", 32'(match_offset), 32'(want.offset));
                    end
                end
            end
            if (cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    // watchdog on cycles with no request accepted
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("masked_signature_scan_extract: mismatch");
        $finish;
    end

    // stimulus plan, reset and end of run
    initial
    begin
        int unsigned                  rand_start;
        int unsigned                  phase;
        int unsigned                  nblk;
        int unsigned                  blen;
        int unsigned                  roll;
        int unsigned                  eff_len;
        logic [mssx_pkg::PLEN_W-1:0]  plen;
        logic [mssx_pkg::CFG_W-1:0]   word;

        // reset values: one-byte window, no compare, offset zero match
        plan_byte(8'hFF, 1'b1);

        // four-byte signature, found one byte in
        plan_drain();
        plan_write(mssx_pkg::REG_PAT_LO, 64'h0000_0000_EFBE_ADDE);
        plan_write(mssx_pkg::REG_PAT_HI, '0);
        plan_write(mssx_pkg::REG_CMP_EN, 64'h000F);
        plan_write(mssx_pkg::REG_PLEN, 64'd4);
        plan_write(mssx_pkg::REG_FSTART, '0);
        plan_write(mssx_pkg::REG_FBYTES, 64'd4);
        plan_write(mssx_pkg::REG_LIMIT, 64'hFFFF_FFFF);
        plan_byte(8'h00, 1'b0);
        plan_byte(8'hDE, 1'b0);
        plan_byte(8'hAD, 1'b0);
        plan_byte(8'hBE, 1'b0);
        plan_byte(8'hEF, 1'b1);

        // signature split over two blocks is never tested
        plan_byte(8'hDE, 1'b1);
        plan_byte(8'hAD, 1'b0);
        plan_byte(8'hBE, 1'b0);
        plan_byte(8'hEF, 1'b1);

        // zero length acts as one, field past the window reads zero, upper bits ignored
        plan_drain();
        plan_write(mssx_pkg::REG_PLEN, '0);
        plan_write(mssx_pkg::REG_CMP_EN, 64'hFFFF_FFFF_FFFF_0001);
        plan_write(mssx_pkg::REG_PAT_LO, 64'h0000_0000_0000_00AA);
        plan_write(mssx_pkg::REG_FSTART, 64'hFFFF_FFFF_FFFF_FFF1);
        plan_write(mssx_pkg::REG_FBYTES, 64'hFFFF_FFFF_FFFF_FFF9);
        plan_write(mssx_pkg::REG_LIMIT, 64'hFFFF_FFFF_0000_0080);
        plan_byte(8'h55, 1'b0);
        plan_byte(8'hAA, 1'b1);

        // first match over the limit is rejected, the next one is kept
        plan_drain();
        plan_write(mssx_pkg::REG_PLEN, 64'd2);
        plan_byte(8'hAA, 1'b0);
        plan_byte(8'h90, 1'b0);
        plan_byte(8'hAA, 1'b0);
        plan_byte(8'h10, 1'b1);

        // zero limit rejects everything, spare index changes nothing
        plan_drain();
        plan_write(mssx_pkg::REG_LIMIT, '0);
        plan_write(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_byte(8'hAA, 1'b0);
        plan_byte(8'h00, 1'b1);

        // random phases: fresh settings, then a run of blocks
        rand_start = planned_bytes;
        phase = 0;
        while (planned_bytes - rand_start < RANDOM_BYTES)
        begin
            plan_drain();
            roll = $urandom_range(9, 0);
            case (roll)
                0:       plen = '0;
                1:       plen = mssx_pkg::PLEN_W'(mssx_pkg::MAX_PATTERN_DEF);
                2:       plen = mssx_pkg::PLEN_W'($urandom_range(31, 17));
                3:       plen = 5'd1;
                default: plen = mssx_pkg::PLEN_W'($urandom_range(8, 2));
            endcase
            eff_len = clamp_len(plen);
            plan_write(mssx_pkg::REG_PAT_LO, {$urandom, $urandom});
            plan_write(mssx_pkg::REG_PAT_HI, {$urandom, $urandom});
            word = {$urandom, $urandom};
            roll = $urandom_range(3, 0);
            if (roll == 0)
            begin
                word[mssx_pkg::CMPEN_W-1:0] = '1;
            end
            else if (roll == 1)
            begin
                word[mssx_pkg::CMPEN_W-1:0] = word[mssx_pkg::CMPEN_W-1:0]
                                              & mssx_pkg::CMPEN_W'($urandom & $urandom);
            end
            plan_write(mssx_pkg::REG_CMP_EN, word);
            word = {$urandom, $urandom};
            word[mssx_pkg::PLEN_W-1:0] = plen;
            plan_write(mssx_pkg::REG_PLEN, word);
            word = {$urandom, $urandom};
            if ($urandom_range(1, 0) == 0)
            begin
                word[mssx_pkg::FSTART_W-1:0] = mssx_pkg::FSTART_W'($urandom_range(eff_len - 1, 0));
            end
            plan_write(mssx_pkg::REG_FSTART, word);
            plan_write(mssx_pkg::REG_FBYTES, {$urandom, $urandom});
            word = {$urandom, $urandom};
            roll = $urandom_range(5, 0);
            if (roll == 0)
            begin
                word[mssx_pkg::VALUE_W-1:0] = '0;
            end
            else if (roll == 1)
            begin
                word[mssx_pkg::VALUE_W-1:0] = '1;
            end
            else if (roll == 2)
            begin
                word[mssx_pkg::VALUE_W-1:0] = word[mssx_pkg::VALUE_W-1:0] >> $urandom_range(31, 0);
            end
            plan_write(mssx_pkg::REG_LIMIT, word);

            // the first phase is long and carries the receiver hold-off
            if (phase == 0)
            begin
                nblk = 40;
                hold_mark = planned_bytes + 30;
            end
            else
            begin
                nblk = $urandom_range(10, 4);
            end
            repeat (nblk)
            begin
                roll = $urandom_range(9, 0);
                if (roll == 0)
                begin
                    blen = $urandom_range(eff_len, 1);
                end
                else
                begin
                    blen = eff_len + $urandom_range(20, 0);
                end
                plan_block(blen, (roll < 7) ? $urandom_range(2, 1) : 32'd0, roll == 7);
            end
            phase++;
        end

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every request and report, then let the pipeline settle
        @(posedge clk);
        while (byte_plan.size() != 0 || in_valid || pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            report_mismatch("reports never delivered", 32'(pending_reports.size()), '0);
        end
        if (error_count == 0)
        begin
            $display("masked_signature_scan_extract: match");
        end
        else
        begin
            $display("masked_signature_scan_extract: mismatch");
        end
        $finish;
    end

endmodule
